FILE: design/rpr_pkg.sv
// rpr_pkg: widths, payload structs, register indexes and constant tables
// for the rotary position rotate block. Depends on nothing.
package rpr_pkg;

    localparam int DATA_W        = 16;
    localparam int POS_W         = 16;
    localparam int IDX_W         = 8;
    localparam int DIM_W         = 10;
    localparam int LB_W          = 22;
    localparam int MAX_DIM       = 512;
    localparam int CORDIC_STAGES = 16;
    localparam int STG_W         = $clog2(CORDIC_STAGES);
    localparam int GUARD         = 32 - DATA_W;
    localparam int CW            = 35;   // CORDIC x/y width
    localparam int ZW            = 33;   // CORDIC angle width
    localparam int NUM_W         = IDX_W + LB_W;
    localparam int DEN_W         = 9;
    localparam int Q_W           = 22;
    localparam int EXP_STAGES    = 16;
    localparam int G_W           = 46;
    localparam int G_LO_W        = 23;
    localparam int PROD_W        = 62;
    localparam int MP_W          = 66;
    localparam int R_W           = 20;

    localparam logic [29:0]        INV_TWO_PI = 30'd683565276;
    localparam logic signed [30:0] GAIN_Q30   = 31'sd652032874;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DIM       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOG2_BASE = 2'd1;

    typedef struct packed {
        logic                     err;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic [NUM_W-1:0]         num;
        logic [DEN_W-1:0]         den;
        logic [DEN_W-1:0]         rem;
        logic [Q_W-1:0]           quo;
    } div_t;

    typedef struct packed {
        logic                     err;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic [5:0]               ei;
        logic [15:0]              ef;
        logic [32:0]              m;
    } exp_t;

    typedef struct packed {
        logic                 err;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cor_t;

    function automatic logic [63:0] isqrt64(logic [63:0] n0);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n0;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b = b >> 2;
        while (b != 64'd0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^-(2^-k) in Q32 for k = 1..16, by repeated floor square roots
    function automatic logic [EXP_STAGES:1][31:0] build_exp();
        logic [EXP_STAGES:1][31:0] tab;
        logic [63:0] t;
        t = isqrt64(64'h8000_0000_0000_0000);
        tab[1] = t[31:0];
        for (int k = 2; k <= EXP_STAGES; k++)
        begin
            t = isqrt64({t[31:0], 32'd0});
            tab[k] = t[31:0];
        end
        return tab;
    endfunction

    // atan(2^-k) in Q32 turns
    function automatic logic [CORDIC_STAGES-1:0][31:0] build_atan();
        logic [CORDIC_STAGES-1:0][31:0] tab;
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] w;
        int p;
        for (int k = 0; k < CORDIC_STAGES; k++)
        begin
            if (k == 0)
            begin
                tab[k] = 32'h2000_0000;
            end
            else
            begin
                s = 64'd0;
                for (int n = 0; k * (2 * n + 1) <= 60; n++)
                begin
                    p = k * (2 * n + 1);
                    t = (64'd1 << (60 - p)) / 64'(2 * n + 1);
                    if (n % 2 == 1) s = s - t;
                    else s = s + t;
                end
                w = ((s >> 28) * 64'(INV_TWO_PI)) >> 32;
                tab[k] = w[31:0];
            end
        end
        return tab;
    endfunction

    localparam logic [EXP_STAGES:1][31:0]      EXP_TAB  = build_exp();
    localparam logic [CORDIC_STAGES-1:0][31:0] ATAN_TAB = build_atan();

endpackage

FILE: design/rpr_in_if.sv
// rpr_in_if: input request channel (position, pair index, activation pair).
// Depends on rpr_pkg.
interface rpr_in_if
    import rpr_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [POS_W-1:0]         position;
    logic [IDX_W-1:0]         pair_index;
    logic signed [DATA_W-1:0] x_even;
    logic signed [DATA_W-1:0] x_odd;

    modport source (output valid, position, pair_index, x_even, x_odd, input ready);
    modport sink   (input valid, position, pair_index, x_even, x_odd, output ready);
endinterface

FILE: design/rpr_out_if.sv
// rpr_out_if: result request channel (rotated pair and flags).
// Depends on rpr_pkg.
interface rpr_out_if
    import rpr_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] y_even;
    logic signed [DATA_W-1:0] y_odd;
    logic                     clipped;
    logic                     index_error;

    modport source (output valid, y_even, y_odd, clipped, index_error, input ready);
    modport sink   (input valid, y_even, y_odd, clipped, index_error, output ready);
endinterface

FILE: design/rpr_cfg_if.sv
// rpr_cfg_if: configuration write channel (register index and data).
// Depends on rpr_pkg.
interface rpr_cfg_if
    import rpr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [LB_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/rpr_div_cell.sv
// rpr_div_cell: one restoring-division cell, one quotient bit per request.
// Depends on rpr_pkg.
module rpr_div_cell
    import rpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [4:0] k,
    input  logic       in_valid,
    input  div_t       in_data,
    output logic       up_ready,
    output logic       out_valid,
    output div_t       out_data,
    input  logic       down_ready
);
    logic       v_reg;
    div_t       d_reg;
    div_t       d_next;
    logic [4:0] bpos;
    logic [DEN_W:0] trial;

    assign up_ready  = !v_reg || down_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    always_comb
    begin
        d_next = in_data;
        bpos   = 5'(Q_W - 1) - k;
        trial  = {in_data.rem, in_data.num[bpos]};
        if (trial >= {1'b0, in_data.den})
        begin
            d_next.rem = DEN_W'(trial - {1'b0, in_data.den});
            d_next.quo = {in_data.quo[Q_W-2:0], 1'b1};
        end
        else
        begin
            d_next.rem = trial[DEN_W-1:0];
            d_next.quo = {in_data.quo[Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && in_valid)
            d_reg <= d_next;
    end
endmodule

FILE: design/rpr_exp_cell.sv
// rpr_exp_cell: one exp2 cell, multiplies by 2^-(2^-k) when bit 16-k of ef is set.
// Depends on rpr_pkg (EXP_TAB).
module rpr_exp_cell
    import rpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [4:0] k,
    input  logic       in_valid,
    input  exp_t       in_data,
    output logic       up_ready,
    output logic       out_valid,
    output exp_t       out_data,
    input  logic       down_ready
);
    logic        v_reg;
    exp_t        d_reg;
    exp_t        d_next;
    logic [3:0]  bsel;
    logic [64:0] prod;

    assign up_ready  = !v_reg || down_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    always_comb
    begin
        d_next = in_data;
        bsel   = 4'(5'(EXP_STAGES) - k);
        prod   = 65'(in_data.m) * 65'(EXP_TAB[k[3:0] == 4'd0 ? 5'd16 : k]);
        if (in_data.ef[bsel])
            d_next.m = prod[64:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && in_valid)
            d_reg <= d_next;
    end
endmodule

FILE: design/rpr_cordic_cell.sv
// rpr_cordic_cell: one CORDIC rotation cell with shift k.
// Depends on rpr_pkg (ATAN_TAB).
module rpr_cordic_cell
    import rpr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [STG_W-1:0] k,
    input  logic             in_valid,
    input  cor_t             in_data,
    output logic             up_ready,
    output logic             out_valid,
    output cor_t             out_data,
    input  logic             down_ready
);
    logic                 v_reg;
    cor_t                 d_reg;
    cor_t                 d_next;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] at;

    assign up_ready  = !v_reg || down_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    always_comb
    begin
        d_next = in_data;
        dx = in_data.y >>> k;
        dy = in_data.x >>> k;
        at = $signed({1'b0, ATAN_TAB[k]});
        if (!in_data.z[ZW-1])
        begin
            d_next.x = in_data.x - dx;
            d_next.y = in_data.y + dy;
            d_next.z = in_data.z - at;
        end
        else
        begin
            d_next.x = in_data.x + dx;
            d_next.y = in_data.y - dy;
            d_next.z = in_data.z + at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && in_valid)
            d_reg <= d_next;
    end
endmodule

FILE: design/rotary_position_rotate.sv
// rotary_position_rotate: top level of the rotary position rotation block.
// Depends on rpr_pkg, the channel interfaces and the div/exp/cordic cells.
//
//   channel | dir | payload                                   | accept
//   item    | in  | position, pair_index, x_even, x_odd       | valid & ready
//   result  | out | y_even, y_odd, clipped, index_error       | valid & ready
//   cfg     | in  | index, data (dim, log2_base)              | valid & ready
//
// Throughput is one request per cycle while result is ready; the chain is
// built from 22 division cells (exponent), 16 exp2 cells, three angle
// stages, 16 CORDIC cells, the gain multiply and the output register.
// Reset clears every stage valid bit and loads dim = 64, log2_base = base
// 10000. Every stage holds its request only while the stage after it is
// full and stalled, so bubbles collapse and a waiting result never blocks
// new input while there is space behind it. cfg is always ready.
module rotary_position_rotate
    import rpr_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    rpr_in_if.sink     item,
    rpr_out_if.source  result,
    rpr_cfg_if.sink    cfg
);
    // configuration registers
    logic [DIM_W-1:0] dim_reg;
    logic [LB_W-1:0]  log2_base_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg       <= DIM_W'(64);
            log2_base_reg <= LB_W'(870823);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DIM:       dim_reg       <= cfg.data[DIM_W-1:0];
                REG_LOG2_BASE: log2_base_reg <= cfg.data;
                default:       ;
            endcase
        end
    end

    // input decode: clamp dim, check the pair index, form i*log2_base
    logic [DIM_W-1:0] dim_c;
    logic [DEN_W-1:0] half;
    div_t             div_in;

    always_comb
    begin
        dim_c = (dim_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim_reg;
        half  = dim_c[DIM_W-1:1];
        div_in.err = {1'b0, item.pair_index} >= half;
        div_in.pos = item.position;
        div_in.x   = item.x_even;
        div_in.y   = item.x_odd;
        div_in.num = NUM_W'(item.pair_index) * NUM_W'(log2_base_reg);
        div_in.den = half;
        // quotient stays below 2^Q_W, so the top bits start below the divisor
        div_in.rem = DEN_W'(div_in.num[NUM_W-1:Q_W]);
        div_in.quo = '0;
    end

    // division chain: e = floor(i*log2_base / half)
    logic [Q_W:0] dv_v;
    logic [Q_W:0] dv_r;
    div_t         dv_d [Q_W+1];

    assign dv_v[0]  = item.valid;
    assign dv_d[0]  = div_in;
    assign item.ready = dv_r[0];

    for (genvar j = 0; j < Q_W; j++)
    begin : g_div
        rpr_div_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .k          (5'(j)),
            .in_valid   (dv_v[j]),
            .in_data    (dv_d[j]),
            .up_ready   (dv_r[j]),
            .out_valid  (dv_v[j+1]),
            .out_data   (dv_d[j+1]),
            .down_ready (dv_r[j+1])
        );
    end

    // exp2 chain: m = 2^-(ef/65536) in Q32, ef from the exponent fraction
    logic [EXP_STAGES:0] ex_v;
    logic [EXP_STAGES:0] ex_r;
    exp_t                ex_d [EXP_STAGES+1];

    always_comb
    begin
        ex_d[0].err = dv_d[Q_W].err;
        ex_d[0].pos = dv_d[Q_W].pos;
        ex_d[0].x   = dv_d[Q_W].x;
        ex_d[0].y   = dv_d[Q_W].y;
        ex_d[0].ei  = dv_d[Q_W].quo[Q_W-1:16];
        ex_d[0].ef  = dv_d[Q_W].quo[15:0];
        ex_d[0].m   = 33'h1_0000_0000;
    end
    assign ex_v[0]    = dv_v[Q_W];
    assign dv_r[Q_W]  = ex_r[0];

    for (genvar j = 0; j < EXP_STAGES; j++)
    begin : g_exp
        rpr_exp_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .k          (5'(j + 1)),
            .in_valid   (ex_v[j]),
            .in_data    (ex_d[j]),
            .up_ready   (ex_r[j]),
            .out_valid  (ex_v[j+1]),
            .out_data   (ex_d[j+1]),
            .down_ready (ex_r[j+1])
        );
    end

    // angle stages: g = m/(2*pi), two half products of position*g, shift
    logic                     g_v_reg;
    logic                     g_err_reg;
    logic [POS_W-1:0]         g_pos_reg;
    logic signed [DATA_W-1:0] g_x_reg;
    logic signed [DATA_W-1:0] g_y_reg;
    logic [5:0]               g_ei_reg;
    logic [G_W-1:0]           g_reg;
    logic [62:0]              g_full;

    logic                     p_v_reg;
    logic                     p_err_reg;
    logic signed [DATA_W-1:0] p_x_reg;
    logic signed [DATA_W-1:0] p_y_reg;
    logic [5:0]               p_ei_reg;
    logic [38:0]              p_hi_reg;
    logic [38:0]              p_lo_reg;

    logic                     a_v_reg;
    logic                     a_err_reg;
    logic signed [DATA_W-1:0] a_x_reg;
    logic signed [DATA_W-1:0] a_y_reg;
    logic [31:0]              a_angle_reg;
    logic [PROD_W-1:0]        prod;
    logic [5:0]               sh;
    logic [31:0]              angle_next;

    logic en_g;
    logic en_p;
    logic en_a;

    logic [CORDIC_STAGES:0] cr_v;
    logic [CORDIC_STAGES:0] cr_r;
    cor_t                   cr_d [CORDIC_STAGES+1];

    assign en_a = !a_v_reg || cr_r[0];
    assign en_p = !p_v_reg || en_a;
    assign en_g = !g_v_reg || en_p;
    assign ex_r[EXP_STAGES] = en_g;

    assign g_full = 63'(ex_d[EXP_STAGES].m) * 63'(INV_TWO_PI);

    always_comb
    begin
        prod = (PROD_W'(p_hi_reg) << G_LO_W) + PROD_W'(p_lo_reg);
        sh   = 6'd16 + p_ei_reg;
        // frequency underflows to zero for a shift of 64 or more
        if (p_ei_reg >= 6'd48)
            angle_next = 32'd0;
        else
            angle_next = 32'(prod >> sh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_v_reg <= 1'b0;
            p_v_reg <= 1'b0;
            a_v_reg <= 1'b0;
        end
        else
        begin
            if (en_g) g_v_reg <= ex_v[EXP_STAGES];
            if (en_p) p_v_reg <= g_v_reg;
            if (en_a) a_v_reg <= p_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_g && ex_v[EXP_STAGES])
        begin
            g_err_reg <= ex_d[EXP_STAGES].err;
            g_pos_reg <= ex_d[EXP_STAGES].pos;
            g_x_reg   <= ex_d[EXP_STAGES].x;
            g_y_reg   <= ex_d[EXP_STAGES].y;
            g_ei_reg  <= ex_d[EXP_STAGES].ei;
            g_reg     <= g_full[G_W+15:16];
        end
        if (en_p && g_v_reg)
        begin
            p_err_reg <= g_err_reg;
            p_x_reg   <= g_x_reg;
            p_y_reg   <= g_y_reg;
            p_ei_reg  <= g_ei_reg;
            p_hi_reg  <= 39'(g_pos_reg) * 39'(g_reg[G_W-1:G_LO_W]);
            p_lo_reg  <= 39'(g_pos_reg) * 39'(g_reg[G_LO_W-1:0]);
        end
        if (en_a && p_v_reg)
        begin
            a_err_reg   <= p_err_reg;
            a_x_reg     <= p_x_reg;
            a_y_reg     <= p_y_reg;
            a_angle_reg <= angle_next;
        end
    end

    // quarter-turn fold: negate the vector and remove half a turn
    logic signed [ZW-1:0] z0;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;

    always_comb
    begin
        z0 = ZW'($signed(a_angle_reg));
        x0 = CW'($signed({a_x_reg, GUARD'(0)}));
        y0 = CW'($signed({a_y_reg, GUARD'(0)}));
        cr_d[0].err = a_err_reg;
        cr_d[0].x   = x0;
        cr_d[0].y   = y0;
        cr_d[0].z   = z0;
        if (z0 > (ZW'(1) <<< 30))
        begin
            cr_d[0].x = -x0;
            cr_d[0].y = -y0;
            cr_d[0].z = z0 - (ZW'(1) <<< 31);
        end
        else if (z0 < -(ZW'(1) <<< 30))
        begin
            cr_d[0].x = -x0;
            cr_d[0].y = -y0;
            cr_d[0].z = z0 + (ZW'(1) <<< 31);
        end
    end
    assign cr_v[0] = a_v_reg;

    for (genvar j = 0; j < CORDIC_STAGES; j++)
    begin : g_cordic
        rpr_cordic_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .k          (STG_W'(j)),
            .in_valid   (cr_v[j]),
            .in_data    (cr_d[j]),
            .up_ready   (cr_r[j]),
            .out_valid  (cr_v[j+1]),
            .out_data   (cr_d[j+1]),
            .down_ready (cr_r[j+1])
        );
    end

    // gain correction multiply, then round half up and saturate
    logic                   m_v_reg;
    logic                   m_err_reg;
    logic signed [MP_W-1:0] m_e_reg;
    logic signed [MP_W-1:0] m_o_reg;
    logic                   en_m;
    logic                   en_o;

    logic                     o_v_reg;
    logic signed [DATA_W-1:0] o_e_reg;
    logic signed [DATA_W-1:0] o_o_reg;
    logic                     o_clip_reg;
    logic                     o_ierr_reg;

    logic signed [MP_W-1:0]   rnd_e;
    logic signed [MP_W-1:0]   rnd_o;
    logic signed [R_W-1:0]    r_e;
    logic signed [R_W-1:0]    r_o;
    logic signed [DATA_W-1:0] s_e;
    logic signed [DATA_W-1:0] s_o;
    logic                     clip_e;
    logic                     clip_o;

    localparam logic signed [R_W-1:0] SAT_HI = R_W'((1 << (DATA_W - 1)) - 1);
    localparam logic signed [R_W-1:0] SAT_LO = -SAT_HI - R_W'(1);

    assign en_o = !o_v_reg || result.ready;
    assign en_m = !m_v_reg || en_o;
    assign cr_r[CORDIC_STAGES] = en_m;

    always_comb
    begin
        rnd_e = m_e_reg + (MP_W'(1) <<< (GUARD + 29));
        rnd_o = m_o_reg + (MP_W'(1) <<< (GUARD + 29));
        r_e   = R_W'(rnd_e >>> (GUARD + 30));
        r_o   = R_W'(rnd_o >>> (GUARD + 30));
        clip_e = (r_e > SAT_HI) || (r_e < SAT_LO);
        clip_o = (r_o > SAT_HI) || (r_o < SAT_LO);
        if (r_e > SAT_HI)      s_e = DATA_W'(SAT_HI);
        else if (r_e < SAT_LO) s_e = DATA_W'(SAT_LO);
        else                   s_e = DATA_W'(r_e);
        if (r_o > SAT_HI)      s_o = DATA_W'(SAT_HI);
        else if (r_o < SAT_LO) s_o = DATA_W'(SAT_LO);
        else                   s_o = DATA_W'(r_o);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (en_m) m_v_reg <= cr_v[CORDIC_STAGES];
            if (en_o) o_v_reg <= m_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_m && cr_v[CORDIC_STAGES])
        begin
            m_err_reg <= cr_d[CORDIC_STAGES].err;
            m_e_reg   <= MP_W'(cr_d[CORDIC_STAGES].x) * MP_W'(GAIN_Q30);
            m_o_reg   <= MP_W'(cr_d[CORDIC_STAGES].y) * MP_W'(GAIN_Q30);
        end
        if (en_o && m_v_reg)
        begin
            // drop the rotation for an out-of-range pair index
            if (m_err_reg)
            begin
                o_e_reg    <= '0;
                o_o_reg    <= '0;
                o_clip_reg <= 1'b0;
                o_ierr_reg <= 1'b1;
            end
            else
            begin
                o_e_reg    <= s_e;
                o_o_reg    <= s_o;
                o_clip_reg <= clip_e || clip_o;
                o_ierr_reg <= 1'b0;
            end
        end
    end

    assign result.valid       = o_v_reg;
    assign result.y_even      = o_e_reg;
    assign result.y_odd       = o_o_reg;
    assign result.clipped     = o_clip_reg;
    assign result.index_error = o_ierr_reg;
endmodule
